// ===== rtl/core/tkrg_pkg.sv =====
package tkrg_pkg;

    localparam int MaxFriends   = 16;
    localparam int Capacity     = MaxFriends + 1;
    localparam int IndexBits    = 16;
    localparam int FractionBits = 16;
    localparam int ValueBits    = FractionBits + 1;
    localparam int CountBits    = $clog2(Capacity + 1);

    localparam logic [ValueBits-1:0] ONE_FX  = ValueBits'(1) << FractionBits;
    localparam logic [IndexBits-1:0] IDX_MAX = '1;

    // output load kinds
    localparam logic [1:0] OUT_NONE   = 2'd0;
    localparam logic [1:0] OUT_EMPTY  = 2'd1;
    localparam logic [1:0] OUT_SINGLE = 2'd2;
    localparam logic [1:0] OUT_POW    = 2'd3;

    typedef struct packed {
        logic [ValueBits-1:0] value;
        logic [IndexBits-1:0] pos;
    } entry_t;

    typedef struct packed {
        logic       accept;
        logic       setup;
        logic       pow_init;
        logic       mul_step;
        logic       sq_step;
        logic [1:0] out_load;
        logic       pop;
        logic       clear;
    } cmd_t;

    typedef struct packed {
        logic empty_case;
        logic single_case;
        logic e_zero;
        logic out_last;
    } sts_t;

    // Q1.F product, rounded half up; 1.0 passes the other operand through
    function automatic logic [ValueBits-1:0] fx_mul(input logic [ValueBits-1:0] a,
                                                    input logic [ValueBits-1:0] b);
        logic [2*ValueBits-1:0] prod;
        prod = (2*ValueBits)'(a) * (2*ValueBits)'(b)
               + ((2*ValueBits)'(1) << (FractionBits - 1));
        if (a >= ONE_FX)
            return b;
        else if (b >= ONE_FX)
            return a;
        else
            return prod[FractionBits +: ValueBits];
    endfunction

endpackage

// ===== rtl/core/tkrg_ctrl.sv =====
module tkrg_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_last,
    input  logic            out_stall,
    input  tkrg_pkg::sts_t  sts,
    output tkrg_pkg::cmd_t  cmd,
    output logic            in_stall,
    output logic            out_valid
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_INIT  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_SQ    = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = (state_reg == S_OUT);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (in_last)
                        state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                if (sts.empty_case)
                begin
                    cmd.out_load = tkrg_pkg::OUT_EMPTY;
                    state_next   = S_OUT;
                end
                else if (sts.single_case)
                begin
                    cmd.out_load = tkrg_pkg::OUT_SINGLE;
                    state_next   = S_OUT;
                end
                else
                begin
                    cmd.setup  = 1'b1;
                    state_next = S_INIT;
                end
            end
            S_INIT:
            begin
                cmd.pow_init = 1'b1;
                state_next   = S_MUL;
            end
            S_MUL:
            begin
                if (sts.e_zero)
                begin
                    cmd.out_load = tkrg_pkg::OUT_POW;
                    state_next   = S_OUT;
                end
                else
                begin
                    cmd.mul_step = 1'b1;
                    state_next   = S_SQ;
                end
            end
            S_SQ:
            begin
                cmd.sq_step = 1'b1;
                state_next  = S_MUL;
            end
            S_OUT:
            begin
                if (!out_stall)
                begin
                    if (sts.out_last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.pop    = 1'b1;
                        state_next = S_INIT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

// ===== rtl/core/tkrg_dp.sv =====
module tkrg_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tkrg_pkg::cmd_t                       cmd,
    output tkrg_pkg::sts_t                       sts,
    input  logic [5:0]                           max_friends,
    input  logic [tkrg_pkg::ValueBits-1:0]       rank_value,
    input  logic                                 missing,
    output logic [tkrg_pkg::IndexBits-1:0]       entity_index,
    output logic [tkrg_pkg::ValueBits-1:0]       p_value,
    output logic                                 last_of_run,
    output logic                                 empty_list
);

    localparam int VB = tkrg_pkg::ValueBits;
    localparam int IB = tkrg_pkg::IndexBits;
    localparam int CB = tkrg_pkg::CountBits;
    localparam int CP = tkrg_pkg::Capacity;

    tkrg_pkg::entry_t heap_reg [CP];
    tkrg_pkg::entry_t heap_next [CP];
    logic [CB-1:0] cnt_reg;
    logic [IB-1:0] len_reg;
    logic [IB-1:0] pres_reg;
    logic [VB-1:0] r_reg;
    logic [VB-1:0] b_reg;
    logic [IB-1:0] e_reg;
    logic [CB-1:0] rem_reg;
    logic [IB-1:0] idx_reg;
    logic [VB-1:0] p_reg;
    logic          last_reg;
    logic          empty_reg;

    // insertion
    logic [VB-1:0] v_sat;
    logic [IB-1:0] len_inc;
    logic          full;
    logic          take;
    logic [CB-1:0] cnt_eff;
    logic [CP-1:0] gt;

    // report setup
    logic [IB-1:0] lm1;
    logic [IB-1:0] kk;
    logic [CB-1:0] kcap;
    logic [CB-1:0] m_all;
    logic [CB-1:0] m_use;

    logic [VB-1:0] mul_a;
    logic [VB-1:0] mul_y;

    assign v_sat   = (rank_value > tkrg_pkg::ONE_FX) ? tkrg_pkg::ONE_FX : rank_value;
    assign len_inc = (len_reg == tkrg_pkg::IDX_MAX) ? len_reg : len_reg + IB'(1);
    assign full    = (cnt_reg == CB'(CP));
    assign take    = !missing && (!full || (v_sat < heap_reg[CP-1].value));
    assign cnt_eff = full ? CB'(CP - 1) : cnt_reg;

    always_comb
    begin
        for (int i = 0; i < CP; i++)
        begin
            gt[i] = (CB'(i) < cnt_eff) && (heap_reg[i].value > v_sat);
        end
        for (int i = 0; i < CP; i++)
        begin
            heap_next[i] = heap_reg[i];
            if (cmd.pop)
            begin
                if (i < CP - 1)
                    heap_next[i] = heap_reg[i + 1];
            end
            else if (take && (CB'(i) <= cnt_eff))
            begin
                if (i > 0 && gt[(i > 0) ? i - 1 : 0])
                    heap_next[i] = heap_reg[(i > 0) ? i - 1 : 0];
                else if (gt[i] || CB'(i) == cnt_eff)
                begin
                    heap_next[i].value = v_sat;
                    heap_next[i].pos   = len_inc;
                end
            end
        end
    end

    always_comb
    begin
        lm1 = len_reg - IB'(1);
        if (max_friends[5])
            kk = lm1;
        else if (IB'(max_friends) > lm1)
            kk = lm1;
        else
            kk = IB'(max_friends);
        kcap  = (kk > IB'(tkrg_pkg::MaxFriends)) ? CB'(tkrg_pkg::MaxFriends) : kk[CB-1:0];
        m_all = kcap + CB'(1);
        m_use = (m_all > cnt_reg) ? cnt_reg : m_all;
    end

    assign sts.empty_case  = (kk == '0) || (pres_reg == '0);
    assign sts.single_case = (pres_reg == IB'(1));
    assign sts.e_zero      = (e_reg == '0);
    assign sts.out_last    = last_reg;

    // one shared multiplier: multiply step or squaring step
    assign mul_a = cmd.mul_step ? r_reg : b_reg;
    assign mul_y = tkrg_pkg::fx_mul(mul_a, b_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.accept || cmd.pop)
            heap_reg <= heap_next;
        if (cmd.setup)
            rem_reg <= m_use - CB'(1);
        else if (cmd.pop)
            rem_reg <= rem_reg - CB'(1);
        if (cmd.pow_init)
        begin
            r_reg <= tkrg_pkg::ONE_FX;
            b_reg <= tkrg_pkg::ONE_FX - heap_reg[1].value + heap_reg[0].value;
            e_reg <= pres_reg;
        end
        else if (cmd.mul_step)
        begin
            if (e_reg[0])
                r_reg <= mul_y;
        end
        else if (cmd.sq_step)
        begin
            e_reg <= e_reg >> 1;
            if (e_reg[IB-1:1] != '0)
                b_reg <= mul_y;
        end
        case (cmd.out_load)
            tkrg_pkg::OUT_EMPTY:
            begin
                idx_reg   <= '0;
                p_reg     <= '0;
                last_reg  <= 1'b1;
                empty_reg <= 1'b1;
            end
            tkrg_pkg::OUT_SINGLE:
            begin
                idx_reg   <= IB'(1);
                p_reg     <= heap_reg[0].value;
                last_reg  <= 1'b1;
                empty_reg <= 1'b0;
            end
            tkrg_pkg::OUT_POW:
            begin
                idx_reg   <= heap_reg[0].pos;
                p_reg     <= r_reg;
                last_reg  <= (rem_reg == CB'(1));
                empty_reg <= 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            len_reg  <= '0;
            pres_reg <= '0;
        end
        else if (cmd.clear)
        begin
            cnt_reg  <= '0;
            len_reg  <= '0;
            pres_reg <= '0;
        end
        else if (cmd.accept)
        begin
            len_reg <= len_inc;
            if (!missing && pres_reg != tkrg_pkg::IDX_MAX)
                pres_reg <= pres_reg + IB'(1);
            if (take)
                cnt_reg <= cnt_eff + CB'(1);
        end
    end

    assign entity_index = idx_reg;
    assign p_value      = p_reg;
    assign last_of_run  = last_reg;
    assign empty_list   = empty_reg;

`ifndef SYNTHESIS
    a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CB'(CP))
        else $error("kept count above capacity");
    a_cnt_vs_pres: assert property (@(posedge clk) disable iff (!rst_n)
        (pres_reg < IB'(CP)) |-> (IB'(cnt_reg) == pres_reg))
        else $error("kept count lost track of present count");
    a_pow_init: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pow_init |=> (b_reg <= tkrg_pkg::ONE_FX) && (e_reg >= IB'(2)))
        else $error("bad power operands");
`endif

endmodule

// ===== rtl/core/top_k_rank_gap_p_values.sv =====
// Channel  | Handshake          | Payload
// input    | in_valid/in_stall  | rank_value, missing, last
// output   | out_valid/out_stall| entity_index, p_value, last_of_run, empty_list
// config   | APB write/read     | max_friends at byte address 0
//
// A non-last request is accepted while idle. A last request adds a setup state, then each
// result comes from the shared multiplier's square-and-multiply loop over the bits of n
// (n = present count); an empty or single-entry list is reported without the loop.
// Sorted insertion of up to 17 kept entries happens in the accept cycle.
// One list at a time: in_stall stays high from the last request until its final
// result is taken. A stalled result simply holds in the output registers.
// rst_n clears list state and sets max_friends to -1; kept entries are not cleared.
module top_k_rank_gap_p_values (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [tkrg_pkg::ValueBits-1:0]       rank_value,
    input  logic                                 missing,
    input  logic                                 last,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [tkrg_pkg::IndexBits-1:0]       entity_index,
    output logic [tkrg_pkg::ValueBits-1:0]       p_value,
    output logic                                 last_of_run,
    output logic                                 empty_list,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [2:0]                           paddr,
    input  logic [31:0]                          pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    tkrg_pkg::cmd_t cmd;
    tkrg_pkg::sts_t sts;
    logic [5:0]     max_friends_reg;

    // config register; only word 0 is implemented
    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? 32'(max_friends_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_friends_reg <= 6'h3F;
        else if (psel && penable && pwrite && paddr == 3'd0)
            max_friends_reg <= pwdata[5:0];
    end

    tkrg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_last   (last),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    tkrg_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .max_friends  (max_friends_reg),
        .rank_value   (rank_value),
        .missing      (missing),
        .entity_index (entity_index),
        .p_value      (p_value),
        .last_of_run  (last_of_run),
        .empty_list   (empty_list)
    );

endmodule
